/* rtl/indexed_linked_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// indexed linked list engine assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LINKED_LIST_ENGINE_DEFINES_SVH

// consequent checked in the same cycle
`define ILLE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define ILLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ille_pkg.sv */
// ----------------------------------------------------------------------------
// ille_pkg
// types and constants of the indexed linked list engine
// ----------------------------------------------------------------------------
package ille_pkg;

	localparam int CAPACITY    = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int NUM_W       = $clog2(CAPACITY + 1);
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int ACT_W       = 2;
	localparam int STAT_W      = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_HEAD  = 2'd0,
		ACT_DELETE    = 2'd1,
		ACT_INS_AFTER = 2'd2,
		ACT_READ      = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_LIVE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_LINK,
		S_UNLINK,
		S_HOLD
	} fsm_t;

	typedef struct packed {
		status_t                 status;
		logic [NUM_W-1:0]        new_number;
		logic [VALUE_WIDTH-1:0]  read_value;
		logic [NUM_W-1:0]        read_next;
	} result_t;

endpackage

/* rtl/ille_req_if.sv */
// ----------------------------------------------------------------------------
// ille_req_if
// request channel: action, reference node and data value
// ----------------------------------------------------------------------------
interface ille_req_if import ille_pkg::*;;
	logic                           valid;
	logic                           ready;
	logic [ACT_W-1:0]               action;
	logic [NUM_W-1:0]               position;
	logic signed [VALUE_WIDTH-1:0]  value;

	modport source (output valid, output action, output position, output value,
		input ready);
	modport sink (input valid, input action, input position, input value,
		output ready);
endinterface

/* rtl/ille_rsp_if.sv */
// ----------------------------------------------------------------------------
// ille_rsp_if
// response channel: status, new node number and read data
// ----------------------------------------------------------------------------
interface ille_rsp_if import ille_pkg::*;;
	logic                           valid;
	logic                           ready;
	logic [STAT_W-1:0]              status;
	logic [NUM_W-1:0]               new_number;
	logic signed [VALUE_WIDTH-1:0]  read_value;
	logic [NUM_W-1:0]               read_next;

	modport source (output valid, output status, output new_number,
		output read_value, output read_next, input ready);
	modport sink (input valid, input status, input new_number,
		input read_value, input read_next, output ready);
endinterface

/* rtl/indexed_linked_list_engine.sv */
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// singly linked list kept in next-pointer, value and deleted-bit memories
// ----------------------------------------------------------------------------
// flow: a request is handled in S_LOOK, then the output register; a successful
//   insert after a node adds S_LINK, and a delete that unlinks a node adds S_UNLINK
// items: one at a time, request ready only in S_IDLE; a new item is taken while
//   a response waits in the output register, not while one waits in res_q
// reset: head pointer and insertion counter clear; liveness is counter plus
//   deleted bit, so the memories need no clearing pass
module indexed_linked_list_engine import ille_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ille_req_if.sink  req,
	ille_rsp_if.source rsp
);

	fsm_t                   state_q, state_d;
	action_t                act_q;
	logic [NUM_W-1:0]       pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [NUM_W-1:0]       head_q, head_d;
	logic [NUM_W-1:0]       count_q, count_d;
	logic [ADDR_W-1:0]      victim_idx_q, victim_idx_d;
	result_t                out_q, res_q, out_data, res;
	logic                   out_valid_q;
	logic                   out_load, res_load, out_free, accept;

	logic [NUM_W-1:0]       next_mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
	logic                   dead_mem [CAPACITY];
	logic [NUM_W-1:0]       next_rd_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;
	logic                   dead_rd_q;

	logic                   next_we, val_we, dead_we, dead_wdata;
	logic [ADDR_W-1:0]      next_raddr, next_waddr, dead_waddr, rd_addr;
	logic [NUM_W-1:0]       next_wdata, new_num, victim;
	logic [ADDR_W-1:0]      pos_idx, new_idx;
	logic                   pos_ok, full, fin;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign rd_addr  = ADDR_W'(req.position - 1'b1);
	assign pos_idx  = ADDR_W'(pos_q - 1'b1);
	assign new_num  = count_q + 1'b1;
	assign new_idx  = ADDR_W'(count_q);
	assign full     = (count_q == NUM_W'(CAPACITY));
	assign pos_ok   = (pos_q == '0) || ((pos_q <= count_q) && !dead_rd_q);
	assign victim   = (pos_q == '0) ? head_q : next_rd_q;

	// memories, read data registered
	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		next_rd_q <= next_mem[next_raddr];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[new_idx] <= val_q;
		end
		val_rd_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (dead_we) begin
			dead_mem[dead_waddr] <= dead_wdata;
		end
		dead_rd_q <= dead_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(req.action);
			pos_q <= req.position;
			val_q <= req.value;
		end
		victim_idx_q <= victim_idx_d;
		if (out_load) begin
			out_q <= out_data;
		end
		if (res_load) begin
			res_q <= res;
		end
	end

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		victim_idx_d = victim_idx_q;
		req.ready    = (state_q == S_IDLE);
		next_raddr   = rd_addr;
		next_we      = 1'b0;
		next_waddr   = new_idx;
		next_wdata   = head_q;
		val_we       = 1'b0;
		dead_we      = 1'b0;
		dead_waddr   = new_idx;
		dead_wdata   = 1'b0;
		res          = '0;
		res.status   = ST_OK;
		fin          = 1'b0;
		out_load     = 1'b0;
		out_data     = res_q;
		res_load     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				unique case (act_q)
					ACT_INS_HEAD, ACT_INS_AFTER: begin
						if (act_q == ACT_INS_AFTER && !pos_ok) begin
							res.status = ST_NOT_LIVE;
							fin        = 1'b1;
						end else if (full) begin
							res.status = ST_FULL;
							fin        = 1'b1;
						end else begin
							next_we    = 1'b1;
							val_we     = 1'b1;
							dead_we    = 1'b1;
							count_d    = new_num;
							if (act_q == ACT_INS_HEAD || pos_q == '0) begin
								next_wdata     = head_q;
								head_d         = new_num;
								res.new_number = new_num;
								fin            = 1'b1;
							end else begin
								next_wdata = next_rd_q;
								state_d    = S_LINK;
							end
						end
					end
					ACT_DELETE: begin
						if (!pos_ok) begin
							res.status = ST_NOT_LIVE;
							fin        = 1'b1;
						end else if (victim == '0) begin
							// nothing follows
							fin = 1'b1;
						end else begin
							next_raddr   = ADDR_W'(victim - 1'b1);
							victim_idx_d = ADDR_W'(victim - 1'b1);
							state_d      = S_UNLINK;
						end
					end
					ACT_READ: begin
						if (!pos_ok) begin
							res.status = ST_NOT_LIVE;
						end else if (pos_q == '0) begin
							res.read_next = head_q;
						end else begin
							res.read_value = val_rd_q;
							res.read_next  = next_rd_q;
						end
						fin = 1'b1;
					end
					default: ;
				endcase
			end
			S_LINK: begin
				// count already holds the new node number
				next_we        = 1'b1;
				next_waddr     = pos_idx;
				next_wdata     = count_q;
				res.new_number = count_q;
				fin            = 1'b1;
			end
			S_UNLINK: begin
				if (pos_q == '0) begin
					head_d = next_rd_q;
				end else begin
					next_we    = 1'b1;
					next_waddr = pos_idx;
					next_wdata = next_rd_q;
				end
				dead_we    = 1'b1;
				dead_waddr = victim_idx_q;
				dead_wdata = 1'b1;
				fin        = 1'b1;
			end
			S_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = res_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// finished item goes to the output register, or waits in res_q
		if (fin) begin
			if (out_free) begin
				out_load = 1'b1;
				out_data = res;
				state_d  = S_IDLE;
			end else begin
				res_load = 1'b1;
				state_d  = S_HOLD;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.new_number = out_q.new_number;
	assign rsp.read_value = $signed(out_q.read_value);
	assign rsp.read_next  = out_q.read_next;

endmodule

/* rtl/ille_checker.sv */
// ----------------------------------------------------------------------------
// ille_checker
// port-level checks of the linked list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "indexed_linked_list_engine_defines.svh"

module ille_checker import ille_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic [STAT_W-1:0]       status,
	input logic [NUM_W-1:0]        new_number,
	input logic [VALUE_WIDTH-1:0]  read_value,
	input logic [NUM_W-1:0]        read_next
);

	`ILLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(new_number) && $stable(read_value) && $stable(read_next), "stalled response item changed")
	`ILLE_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while an item is in progress")
	`ILLE_ASSERT_SAME(a_fault_clean, rsp_valid && status != ST_OK, new_number == '0 && read_value == '0 && read_next == '0, "faulted item carries data")
	`ILLE_ASSERT_SAME(a_status_code, rsp_valid, status == ST_OK || status == ST_FULL || status == ST_NOT_LIVE, "reserved status code")

endmodule

bind indexed_linked_list_engine ille_checker u_ille_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.new_number (rsp.new_number),
	.read_value (rsp.read_value),
	.read_next  (rsp.read_next)
);
